@@ sv/mfvr_pkg.sv @@
// Shared types and constants for the mode-filtered voltage reporter.
// No dependencies; imported by the scaling unit, the top level and the testbench.
package mfvr_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MV_W      = 16;
    localparam int CV_W      = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q8         = 2'd3;

    localparam logic [CFG_W-1:0] RST_REPORT_INTERVAL  = 16'd7000;
    localparam logic [CFG_W-1:0] RST_MEASURE_INTERVAL = 16'd875;
    localparam logic [CFG_W-1:0] RST_CHANGE_THRESHOLD = 16'd100;
    localparam logic [CFG_W-1:0] RST_SCALE_Q8         = 16'd256;

    localparam logic [MV_W-1:0]  MV_MAX      = 16'hFFFF;
    localparam logic [7:0]       Q8_HALF     = 8'd128;
    localparam logic [3:0]       CV_ROUND    = 4'd5;
    // floor(x / 10) == (x * 52429) >> 19 for every x below 2^18
    localparam logic [15:0]      DIV10_RECIP = 16'd52429;
    localparam logic [CV_W-1:0]  CV_MAX      = 13'd6554;

    typedef struct packed {
        logic [CFG_W-1:0] report_interval;
        logic [CFG_W-1:0] measure_interval;
        logic [CFG_W-1:0] change_threshold_mv;
        logic [CFG_W-1:0] scale_q8;
    } t_cfg;

    typedef struct packed {
        logic            report;
        logic [MV_W-1:0] mv;
        logic [CV_W-1:0] cv;
    } t_rpt;

endpackage

@@ sv/mfvr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfvr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/mfvr_mode.sv @@
// Mode search over the store: one compare per M_CMP cycle through the RAM read port.
// Drives the read address of mfvr_ram; no package dependency.
module mfvr_mode #(
    parameter int N = 8,
    parameter int W = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic [$clog2(N)-1:0] o_raddr,
    input  logic [W-1:0]         i_rdata,
    output logic                 o_done,
    output logic [W-1:0]         o_mode
);
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam logic [IW-1:0] LAST = IW'(N - 1);

    typedef enum logic [1:0] {M_IDLE, M_LDI, M_CMP} t_state;

    t_state          r_state;
    logic [IW-1:0]   r_i, r_j;
    logic [W-1:0]    r_cand, r_best_val, r_mode;
    logic [CW-1:0]   r_cnt, r_best_cnt;
    logic            r_done;
    logic [CW-1:0]   n_cnt;
    logic            better;

    assign n_cnt  = r_cnt + CW'(i_rdata == r_cand);
    assign better = n_cnt > r_best_cnt;

    always_comb begin
        unique case (r_state)
            M_IDLE:  o_raddr = '0;
            M_LDI:   o_raddr = '0;
            M_CMP:   o_raddr = (r_j == LAST) ? IW'(r_i + 1'b1) : IW'(r_j + 1'b1);
            default: o_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_i        <= '0;
                        r_best_cnt <= '0;
                        r_best_val <= '0;
                        r_state    <= M_LDI;
                    end
                end
                M_LDI: begin
                    r_cand  <= i_rdata;
                    r_j     <= '0;
                    r_cnt   <= '0;
                    r_state <= M_CMP;
                end
                M_CMP: begin
                    if (r_j != LAST) begin
                        r_j   <= IW'(r_j + 1'b1);
                        r_cnt <= n_cnt;
                    end else begin
                        // strict compare: earliest candidate keeps a tie
                        if (better) begin
                            r_best_cnt <= n_cnt;
                            r_best_val <= r_cand;
                        end
                        if (r_i == LAST) begin
                            if (better) begin
                                r_mode <= (n_cnt > CW'(1)) ? r_cand : '0;
                            end else begin
                                r_mode <= (r_best_cnt > CW'(1)) ? r_best_val : '0;
                            end
                            r_done  <= 1'b1;
                            r_state <= M_IDLE;
                        end else begin
                            r_i     <= IW'(r_i + 1'b1);
                            r_state <= M_LDI;
                        end
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_mode = r_mode;
endmodule

@@ sv/mfvr_scale.sv @@
// Scales the mode to millivolts, decides on a report and converts to centivolts.
// Three register stages; uses mfvr_pkg types.
module mfvr_scale #(
    parameter int W = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_mode,
    input  mfvr_pkg::t_cfg        i_cfg,
    input  logic [mfvr_pkg::MV_W-1:0] i_last_mv,
    output logic                  o_done,
    output mfvr_pkg::t_rpt        o_rpt
);
    import mfvr_pkg::*;

    localparam int PW = W + CFG_W + 1;

    logic [2:0]       r_v;
    logic [PW-1:0]    r_prod;
    logic [MV_W-1:0]  r_mv;
    logic             r_rep;
    logic [31:0]      r_cvp;
    logic [MV_W-1:0]  mv_sat, diff;
    logic [MV_W:0]    mv_rnd;

    assign mv_sat = (r_prod[PW-1:24] != '0) ? MV_MAX : r_prod[23:8];
    assign diff   = (r_mv > i_last_mv) ? MV_W'(r_mv - i_last_mv) : MV_W'(i_last_mv - r_mv);
    assign mv_rnd = {1'b0, r_mv} + (MV_W + 1)'(CV_ROUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
            if (i_start) begin
                r_prod <= PW'(i_mode) * PW'(i_cfg.scale_q8) + PW'(Q8_HALF);
            end
            if (r_v[0]) begin
                r_mv <= mv_sat;
            end
            if (r_v[1]) begin
                r_rep <= (r_mv != '0) && (diff > i_cfg.change_threshold_mv);
                r_cvp <= 32'(mv_rnd) * 32'(DIV10_RECIP);
            end
        end
    end

    assign o_done       = r_v[2];
    assign o_rpt.report = r_rep;
    assign o_rpt.mv     = r_mv;
    assign o_rpt.cv     = r_cvp[31:19];
endmodule

@@ sv/mode_filtered_voltage_reporter.sv @@
// Mode-filtered voltage reporter. Ordinary ticks are taken with stall staying low.
// A sampling tick also passes through FILL, which with a zero measure interval stays
// on and writes the rest of the store from the same reading. The tick that fills the
// store then waits for the mode search (one RAM read per cycle), scaling and output.
// A round end that reports also waits while an earlier report is still held at the output.
// Reset is synchronous, active low; the sample store is not cleared.
module mode_filtered_voltage_reporter #(
    parameter int SAMPLE_COUNT = 8,
    parameter int ADC_BITS     = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ADC_BITS-1:0]             i_adc_sample,
    // report output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mfvr_pkg::CV_W-1:0]       o_voltage_cv,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [mfvr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfvr_pkg::CFG_W-1:0]      i_cfg_data
);
    import mfvr_pkg::*;

    localparam int IW = $clog2(SAMPLE_COUNT);
    localparam int CW = $clog2(SAMPLE_COUNT + 1);
    localparam logic [CW-1:0] N_CNT = CW'(SAMPLE_COUNT);

    // Tick sequencer: IDLE takes ticks, FILL writes samples into the store one a
    // cycle, SEARCH waits for the mode unit, SCALE for the scaling pipe, OUT
    // places a report, if there is one, in the output register.
    typedef enum logic [2:0] {T_IDLE, T_FILL, T_SEARCH, T_SCALE, T_OUT} t_state;

    t_state               r_state;
    t_cfg                 r_cfg;
    logic [CFG_W-1:0]     r_tsr;       // ticks since the last report, saturating
    logic                 r_active;
    logic [CW-1:0]        r_taken;
    logic [CFG_W-1:0]     r_ttn;       // ticks to next sample
    logic [MV_W-1:0]      r_last_mv;
    logic [ADC_BITS-1:0]  r_sample;
    logic                 r_ov;
    logic [CV_W-1:0]      r_cv;

    logic                 accept, round_start, eff_active, fill_last, out_free, out_load;
    logic                 mode_start, mode_done, scale_start, scale_done;
    logic [CFG_W-1:0]     ttn_dec, tsr_inc;
    logic [CW-1:0]        taken_inc;
    logic [IW-1:0]        raddr;
    logic [ADC_BITS-1:0]  rdata, mode_val;
    t_rpt                 rpt;

    assign accept      = i_valid && (r_state == T_IDLE);
    assign round_start = !r_active && (r_tsr >= r_cfg.report_interval);
    assign eff_active  = r_active || round_start;
    // outside a round the countdown already sits at zero
    assign ttn_dec     = (r_active && r_ttn != '0) ? CFG_W'(r_ttn - 1'b1) : r_ttn;
    assign tsr_inc     = (r_tsr == MV_MAX) ? r_tsr : CFG_W'(r_tsr + 1'b1);
    assign taken_inc   = CW'(r_taken + 1'b1);
    assign fill_last   = taken_inc == N_CNT;
    assign out_free    = !r_ov || !i_stall;
    assign out_load    = (r_state == T_OUT) && rpt.report && out_free;

    // The store is written only in FILL and read only in SEARCH, so the
    // sequencing itself keeps writes and reads of an entry apart.
    assign mode_start  = (r_state == T_FILL) && fill_last;
    assign scale_start = (r_state == T_SEARCH) && mode_done;

    mfvr_ram #(
        .WIDTH (ADC_BITS),
        .DEPTH (SAMPLE_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == T_FILL),
        .i_waddr (r_taken[IW-1:0]),
        .i_wdata (r_sample),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mfvr_mode #(
        .N (SAMPLE_COUNT),
        .W (ADC_BITS)
    ) u_mode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mode_start),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_done  (mode_done),
        .o_mode  (mode_val)
    );

    mfvr_scale #(
        .W (ADC_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scale_start),
        .i_mode    (mode_val),
        .i_cfg     (r_cfg),
        .i_last_mv (r_last_mv),
        .o_done    (scale_done),
        .o_rpt     (rpt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_active  <= 1'b0;
            r_taken   <= '0;
            r_ttn     <= '0;
            r_tsr     <= '0;
            r_last_mv <= '0;
            r_ov      <= 1'b0;
            r_cfg.report_interval     <= RST_REPORT_INTERVAL;
            r_cfg.measure_interval    <= RST_MEASURE_INTERVAL;
            r_cfg.change_threshold_mv <= RST_CHANGE_THRESHOLD;
            r_cfg.scale_q8            <= RST_SCALE_Q8;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_REPORT_INTERVAL:  r_cfg.report_interval     <= i_cfg_data;
                    REG_MEASURE_INTERVAL: r_cfg.measure_interval    <= i_cfg_data;
                    REG_CHANGE_THRESHOLD: r_cfg.change_threshold_mv <= i_cfg_data;
                    REG_SCALE_Q8:         r_cfg.scale_q8            <= i_cfg_data;
                    default: ;
                endcase
            end

            // a new report may replace one that leaves in this same cycle
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_sample <= i_adc_sample;
                        r_tsr    <= tsr_inc;   // a report later in this item clears it
                        r_active <= eff_active;
                        r_ttn    <= ttn_dec;
                        if (eff_active && ttn_dec == '0) begin
                            r_state <= T_FILL;
                        end
                    end
                end
                T_FILL: begin
                    r_taken <= taken_inc;
                    r_ttn   <= r_cfg.measure_interval;
                    if (fill_last) begin
                        r_state <= T_SEARCH;
                    end else if (r_cfg.measure_interval != '0) begin
                        r_state <= T_IDLE;
                    end
                end
                T_SEARCH: begin
                    if (mode_done) begin
                        r_state <= T_SCALE;
                    end
                end
                T_SCALE: begin
                    if (scale_done) begin
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (!rpt.report || out_free) begin
                        if (rpt.report) begin
                            r_cv      <= rpt.cv;
                            r_last_mv <= rpt.mv;
                            r_tsr     <= '0;
                        end
                        r_active <= 1'b0;
                        r_taken  <= '0;
                        r_ttn    <= '0;
                        r_state  <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_stall      = r_state != T_IDLE;
    assign o_valid      = r_ov;
    assign o_voltage_cv = r_cv;

    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= N_CNT)
        else $error("sample count ran past the store depth");

    a_fill_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_FILL) |-> r_active)
        else $error("store written outside a round");

    a_report_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_last_mv != '0) && (r_tsr == '0) && !r_active)
        else $error("report did not update last value and timer");

    a_cv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_voltage_cv <= CV_MAX))
        else $error("reported voltage out of range");

    a_search_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_start |=> (r_state == T_SEARCH) && o_stall)
        else $error("ticks taken during mode search");
endmodule

@@ tb/mode_filtered_voltage_reporter_tb.sv @@
// Self-checking testbench for the mode-filtered voltage reporter.
// Needs mfvr_pkg and the block itself; holds its own tick predictor and result scoreboard.
module mode_filtered_voltage_reporter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfvr_pkg::*;

    localparam int SAMPLE_COUNT = 8;
    localparam int ADC_BITS     = 12;

    localparam int      CLK_PERIOD     = 12;
    localparam int      RESET_CYCLES   = 12;
    // the slowest item is a round end, with its mode search and scaling
    localparam int      SETTLE_CYCLES  = 200;
    localparam int      HOLD_OFF_CYCLES = 400;
    localparam int      END_WAIT_LIMIT = 20000;
    localparam longint  TIMEOUT_CYCLES = 600_000;

    // ---------------------------------------------------------------
    // Block interface; every input starts at a known value
    // ---------------------------------------------------------------
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    logic [ADC_BITS-1:0]   i_adc_sample = '0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic [CV_W-1:0]       o_voltage_cv;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_W-1:0]      i_cfg_data   = '0;

    mode_filtered_voltage_reporter #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .ADC_BITS     (ADC_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_adc_sample (i_adc_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_voltage_cv (o_voltage_cv),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Voltage predictor and report scoreboard.
    // Keeps its own copy of the registers and of the sampling state;
    // each accepted tick may queue one expected centivolt report.
    // ---------------------------------------------------------------
    class report_scoreboard;
        logic [CFG_W-1:0]    report_iv;
        logic [CFG_W-1:0]    measure_iv;
        logic [CFG_W-1:0]    thresh_mv;
        logic [CFG_W-1:0]    scale;

        logic [15:0]         tick_count;
        bit                  in_round;
        int unsigned         n_taken;
        logic [15:0]         countdown;
        logic [ADC_BITS-1:0] samples [SAMPLE_COUNT];
        logic [MV_W-1:0]     last_mv;

        logic [CV_W-1:0]     expected_cv [$];
        int unsigned         failures;
        int unsigned         ticks_seen;
        int unsigned         reports_seen;

        function new();
            report_iv    = RST_REPORT_INTERVAL;
            measure_iv   = RST_MEASURE_INTERVAL;
            thresh_mv    = RST_CHANGE_THRESHOLD;
            scale        = RST_SCALE_Q8;
            tick_count   = '0;
            in_round     = 1'b0;
            n_taken      = 0;
            countdown    = '0;
            last_mv      = '0;
            failures     = 0;
            ticks_seen   = 0;
            reports_seen = 0;
            foreach (samples[k]) samples[k] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_REPORT_INTERVAL:  report_iv  = val;
                REG_MEASURE_INTERVAL: measure_iv = val;
                REG_CHANGE_THRESHOLD: thresh_mv  = val;
                REG_SCALE_Q8:         scale      = val;
                default: ;
            endcase
        endfunction

        // Earliest value with the highest count; zero when every sample is unique
        function int unsigned store_mode();
            int unsigned best_cnt;
            int unsigned best_val;
            int unsigned cnt;
            best_cnt = 0;
            best_val = 0;
            for (int a = 0; a < SAMPLE_COUNT; a++) begin
                cnt = 0;
                for (int b = 0; b < SAMPLE_COUNT; b++) begin
                    if (samples[a] == samples[b]) cnt++;
                end
                if (cnt > best_cnt) begin
                    best_cnt = cnt;
                    best_val = samples[a];
                end
            end
            return (best_cnt > 1) ? best_val : 0;
        endfunction

        function void note_tick(logic [ADC_BITS-1:0] reading);
            int unsigned mv;
            int unsigned delta;
            bit          reported;
            reported = 1'b0;
            ticks_seen++;

            if (!in_round && tick_count >= report_iv) begin
                in_round  = 1'b1;
                n_taken   = 0;
                countdown = '0;
            end

            if (in_round) begin
                if (countdown != 0) countdown--;
                // zero measure interval fills the rest of the store from this reading
                while (countdown == 0 && n_taken < SAMPLE_COUNT) begin
                    samples[n_taken] = reading;
                    n_taken++;
                    countdown = measure_iv;
                end
                if (n_taken >= SAMPLE_COUNT) begin
                    mv = (store_mode() * scale + Q8_HALF) >> 8;
                    if (mv > MV_MAX) mv = MV_MAX;
                    delta = (mv > last_mv) ? mv - last_mv : last_mv - mv;
                    in_round  = 1'b0;
                    n_taken   = 0;
                    countdown = '0;
                    if (mv != 0 && delta > thresh_mv) begin
                        last_mv = MV_W'(mv);
                        expected_cv.push_back(CV_W'((mv + CV_ROUND) / 10));
                        reported = 1'b1;
                    end
                end
            end

            if (reported) tick_count = '0;
            else if (tick_count != 16'hFFFF) tick_count++;
        endfunction

        function void log_failure(string what, int unsigned want, int unsigned got);
            failures++;
            if (failures <= 10)
                $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
        endfunction

        function void check_report(logic [CV_W-1:0] cv);
            logic [CV_W-1:0] want;
            reports_seen++;
            if (expected_cv.size() == 0) begin
                log_failure("report with none pending, voltage_cv", 0, cv);
            end else begin
                want = expected_cv.pop_front();
                if (cv !== want) log_failure("voltage_cv mismatch", want, cv);
            end
        endfunction

        function int pending();
            return expected_cv.size();
        endfunction

        function void flag_leftovers();
            while (expected_cv.size() != 0)
                log_failure("report never arrived, voltage_cv", expected_cv.pop_front(), 0);
        endfunction
    endclass

    report_scoreboard sb = new();

    // ---------------------------------------------------------------
    // Monitors: sample both handshakes at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_tick(i_adc_sample);
        if (i_rst_n && o_valid && !i_stall) sb.check_report(o_voltage_cv);
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ---------------------------------------------------------------
    bit rx_idle_en   = 1'b1;
    bit tx_idle_en   = 1'b1;
    bit hold_off_req = 1'b0;

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    int unsigned         settings_used = 0;
    logic [ADC_BITS-1:0] level         = 12'd1000;

    // One item per call; an idle burst may come first
    task automatic send_tick(input logic [ADC_BITS-1:0] reading);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_adc_sample <= reading;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Lets the block finish whatever round end it is still working on
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // All four registers, back to back; write enable drops once at the end
    task automatic write_config(input logic [CFG_W-1:0] ri, input logic [CFG_W-1:0] mi,
                                input logic [CFG_W-1:0] th, input logic [CFG_W-1:0] sc);
        logic [CFG_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] idxs [4];
        vals = '{ri, mi, th, sc};
        idxs = '{REG_REPORT_INTERVAL, REG_MEASURE_INTERVAL,
                 REG_CHANGE_THRESHOLD, REG_SCALE_Q8};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(idxs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Readings sit mostly on a slowly moving level so that rounds find a mode;
    // near misses and fully random readings make up the rest.
    function automatic logic [ADC_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) level = ADC_BITS'($urandom);
        if (r < 65) return level;
        if (r < 85) return level ^ ADC_BITS'(1 << $urandom_range(0, ADC_BITS - 1));
        return ADC_BITS'($urandom);
    endfunction

    task automatic run_phase(input int n, input logic [CFG_W-1:0] ri,
                             input logic [CFG_W-1:0] mi, input logic [CFG_W-1:0] th,
                             input logic [CFG_W-1:0] sc);
        wait_idle();
        write_config(ri, mi, th, sc);
        for (int k = 0; k < n; k++) send_tick(pick_sample());
        i_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Hard limit on run time
    // ---------------------------------------------------------------
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[%0t] timeout with %0d reports pending", $realtime, sb.pending());
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int wait_count;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero report and zero measure interval, one reading fills a round
        write_config(16'd0, 16'd0, 16'd0, 16'd256);
        send_tick(12'hFFF);          // full-scale reading, reported
        send_tick(12'hFFF);          // same value again: no change, no report
        send_tick(12'h000);          // zero mode: nothing reported
        send_tick(12'h001);          // tiny voltage rounds to zero centivolts
        i_valid <= 1'b0;

        // Directed: one sample per tick, a tie and then an all-distinct round
        wait_idle();
        write_config(16'd0, 16'd1, 16'd0, 16'd256);
        for (int k = 0; k < SAMPLE_COUNT; k++)
            send_tick((k % 2 == 0) ? 12'd10 : 12'd20);
        for (int k = 0; k < SAMPLE_COUNT; k++)
            send_tick(ADC_BITS'(100 + 37 * k));
        i_valid <= 1'b0;

        // Directed: millivolt saturation, then the smallest scale
        wait_idle();
        write_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_tick(12'd2048);
        i_valid <= 1'b0;
        wait_idle();
        write_config(16'd0, 16'd0, 16'd0, 16'd1);
        send_tick(12'hFFF);
        i_valid <= 1'b0;

        // Random: the other register extremes; no round can start here
        run_phase(20, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd256);
        // Rounds in quick succession, every change to a nonzero voltage reported
        run_phase(150, 16'd1, 16'd1, 16'd0, 16'd256);
        // Mixed settings
        for (int p = 0; p < 3; p++)
            run_phase(100, 16'($urandom_range(1, 8)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 300)), 16'($urandom_range(1, 1024)));

        // Back-pressure: the receiver holds off while rounds keep ending
        wait_idle();
        write_config(16'd1, 16'd0, 16'd0, 16'd256);
        hold_off_req = 1'b1;
        for (int k = 0; k < 120; k++) send_tick(pick_sample());
        i_valid <= 1'b0;

        // Scale extremes with one sample per tick
        run_phase(80, 16'd1, 16'd1, 16'd0, 16'hFFFF);
        run_phase(80, 16'd1, 16'd1, 16'd0, 16'd1);

        // Last stretch at full rate on both sides
        wait_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_config(16'd2, 16'd1, 16'd20, 16'd300);
        for (int k = 0; k < 100; k++) send_tick(pick_sample());
        i_valid <= 1'b0;

        wait_count = 0;
        while (sb.pending() != 0 && wait_count < END_WAIT_LIMIT) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();

        $display("Run covered %0d ticks under %0d register settings, %0d reports checked",
                 sb.ticks_seen, settings_used, sb.reports_seen);
        $display("Mismatches and missing or surplus reports: %0d", sb.failures);
        if (sb.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
